@@ hw/rtl/cas_pkg.sv @@
// Shared types and constants of the centroid scaling block.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
package cas_pkg;

  // Field geometry of the Q16.16 coordinates
  localparam int unsigned CoordW   = 32;
  localparam int unsigned NumAxes  = 3;
  localparam int unsigned WordW    = (NumAxes + 1) * CoordW;  // x, y, z and weight
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic signed [CoordW-1:0] OneQ16 = 32'sh0001_0000;

  // Input beat: one vertex
  typedef struct packed {
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic signed [CoordW-1:0] coord_z;
    logic signed [CoordW-1:0] weight;
    logic                     last_vertex;
  } in_beat_t;

  // Output beat: one displacement
  typedef struct packed {
    logic signed [CoordW-1:0] disp_x;
    logic signed [CoordW-1:0] disp_y;
    logic signed [CoordW-1:0] disp_z;
    logic                     last_disp;
  } out_beat_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCALE_X   = 3'd0,
    CFG_SCALE_Y   = 3'd1,
    CFG_SCALE_Z   = 3'd2,
    CFG_FILTER_EN = 3'd3
  } cfg_reg_e;

  // Datapath micro-operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_READ,
    OP_DIFF,
    OP_MUL1,
    OP_ROUND1,
    OP_ADDC,
    OP_MAGT,
    OP_MULLO,
    OP_MULHI,
    OP_COMB,
    OP_FINAL
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic last_k;   // current vertex is the final one of the set
  } dp_sts_t;

endpackage

@@ hw/rtl/cas_ctrl.sv @@
// Controller of the centroid scaling block: sequences load, division and
// the per-vertex emission steps. Depends on cas_pkg.
module cas_ctrl #(
  parameter int unsigned SumW = 38
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  cas_pkg::dp_sts_t  sts_i,
  output cas_pkg::dp_cmd_t  cmd_o
);

  localparam int unsigned StepW = $clog2(SumW);

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_DSTART,
    ST_DIV,
    ST_DEND,
    ST_READ,
    ST_DIFF,
    ST_MUL1,
    ST_ROUND1,
    ST_ADDC,
    ST_MAGT,
    ST_MULLO,
    ST_MULHI,
    ST_COMB,
    ST_FINAL
  } state_e;

  state_e           state_q;
  logic [StepW-1:0] step_q;
  logic             out_valid_q;
  logic             in_acc;
  logic             out_free;
  cas_pkg::dp_op_e  op;

  assign in_stall_o  = (state_q != ST_LOAD);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign cmd_o.op    = op;

  // Decode the datapath operation of the current state
  always_comb begin
    unique case (state_q)
      ST_LOAD:   op = in_acc ? cas_pkg::OP_LOAD : cas_pkg::OP_NONE;
      ST_DSTART: op = cas_pkg::OP_DIV_START;
      ST_DIV:    op = cas_pkg::OP_DIV_STEP;
      ST_DEND:   op = cas_pkg::OP_DIV_END;
      ST_READ:   op = cas_pkg::OP_READ;
      ST_DIFF:   op = cas_pkg::OP_DIFF;
      ST_MUL1:   op = cas_pkg::OP_MUL1;
      ST_ROUND1: op = cas_pkg::OP_ROUND1;
      ST_ADDC:   op = cas_pkg::OP_ADDC;
      ST_MAGT:   op = cas_pkg::OP_MAGT;
      ST_MULLO:  op = cas_pkg::OP_MULLO;
      ST_MULHI:  op = cas_pkg::OP_MULHI;
      ST_COMB:   op = cas_pkg::OP_COMB;
      ST_FINAL:  op = out_free ? cas_pkg::OP_FINAL : cas_pkg::OP_NONE;
      default:   op = cas_pkg::OP_NONE;
    endcase
  end

  // Advance state, count division steps, track the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (op == cas_pkg::OP_FINAL) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_LOAD: begin
          if (in_acc && in_last_i) state_q <= ST_DSTART;
        end
        ST_DSTART: begin
          step_q  <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          step_q <= step_q + StepW'(1);
          if (step_q == StepW'(SumW - 1)) state_q <= ST_DEND;
        end
        ST_DEND:   state_q <= ST_READ;
        ST_READ:   state_q <= ST_DIFF;
        ST_DIFF:   state_q <= ST_MUL1;
        ST_MUL1:   state_q <= ST_ROUND1;
        ST_ROUND1: state_q <= ST_ADDC;
        ST_ADDC:   state_q <= ST_MAGT;
        ST_MAGT:   state_q <= ST_MULLO;
        ST_MULLO:  state_q <= ST_MULHI;
        ST_MULHI:  state_q <= ST_COMB;
        ST_COMB:   state_q <= ST_FINAL;
        ST_FINAL: begin
          if (out_free) state_q <= sts_i.last_k ? ST_LOAD : ST_READ;
        end
        default:   state_q <= ST_LOAD;
      endcase
    end
  end

endmodule

@@ hw/rtl/cas_dpath.sv @@
// Datapath of the centroid scaling block: vertex memory, running sums,
// restoring divider, per-axis multiply lanes and the output register.
// Depends on cas_pkg.
module cas_dpath #(
  parameter int unsigned MaxVertices = 64,
  parameter int unsigned AddrW       = 6,
  parameter int unsigned CntW        = 7,
  parameter int unsigned SumW        = 38
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cas_pkg::dp_cmd_t               cmd_i,
  output cas_pkg::dp_sts_t               sts_o,
  input  cas_pkg::in_beat_t              in_data_i,
  input  logic                           cfg_we_i,
  input  logic [cas_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [cas_pkg::CfgDataW-1:0]   cfg_data_i,
  output cas_pkg::out_beat_t             out_data_o
);

  localparam int unsigned AxN  = cas_pkg::NumAxes;
  localparam int unsigned CW   = cas_pkg::CoordW;
  localparam logic [40:0] MCap = 41'h100_0000_0000;   // any magnitude here saturates
  localparam logic signed [42:0] FMax = 43'sd2147483647;
  localparam logic signed [42:0] FMin = -43'sd2147483648;

  // Configuration
  logic signed [CW-1:0] scale_q [AxN];
  logic                 filt_en_q;

  // Load side
  logic [CntW-1:0]        count_q;
  logic [CntW-1:0]        n_q;
  logic [CntW-1:0]        k_q;
  logic signed [SumW-1:0] sum_q [AxN];
  logic [cas_pkg::WordW-1:0] mem_q [MaxVertices];
  logic [cas_pkg::WordW-1:0] rd_q;
  logic                      store_en;
  logic signed [CW-1:0]      in_p [AxN];

  // Divider lanes
  logic [SumW-1:0] dsh_q [AxN];
  logic [CntW-1:0] rem_q [AxN];
  logic            qneg_q [AxN];
  logic [CntW:0]   rtrial [AxN];
  logic [CntW:0]   rdiff [AxN];
  logic            rge [AxN];
  logic [SumW-1:0] smag_sum [AxN];
  logic [SumW-1:0] cq [AxN];
  logic signed [CW-1:0] c_q [AxN];

  // Emission lanes
  logic signed [CW-1:0] rd_p [AxN];
  logic signed [CW-1:0] rd_w;
  logic signed [CW-1:0] w_sel;
  logic                 wneg;
  logic [CW-1:0]        wmag;
  logic                 sneg [AxN];
  logic [CW-1:0]        smag [AxN];
  logic signed [CW:0]   diff [AxN];
  logic                 dneg_q [AxN];
  logic [CW-1:0]        dmag_q [AxN];
  logic [CW-1:0]        mul_a [AxN];
  logic [CW-1:0]        mul_b [AxN];
  logic [63:0]          mul_res [AxN];
  logic [63:0]          prod_q [AxN];
  logic [63:0]          rnd [AxN];
  logic                 sgn_q [AxN];
  logic [47:0]          m1_q [AxN];
  logic signed [49:0]   t_c [AxN];
  logic signed [49:0]   t_q [AxN];
  logic signed [49:0]   t_neg [AxN];
  logic                 tneg_q [AxN];
  logic [48:0]          tmag_q [AxN];
  logic [48:0]          hi_q [AxN];
  logic [47:0]          lor_q [AxN];
  logic [48:0]          msum [AxN];
  logic                 mbig [AxN];
  logic [40:0]          m_q [AxN];
  logic signed [42:0]   fval [AxN];
  logic signed [CW-1:0] disp [AxN];
  cas_pkg::out_beat_t   out_q;

  assign in_p[0] = in_data_i.coord_x;
  assign in_p[1] = in_data_i.coord_y;
  assign in_p[2] = in_data_i.coord_z;

  assign store_en = (cmd_i.op == cas_pkg::OP_LOAD) && (count_q < CntW'(MaxVertices));
  assign sts_o.last_k = ((k_q + CntW'(1)) == n_q);

  // Weight of the vertex under work
  assign rd_w  = $signed(rd_q[AxN*CW +: CW]);
  assign w_sel = filt_en_q ? rd_w : cas_pkg::OneQ16;
  assign wneg  = w_sel[CW-1];
  assign wmag  = wneg ? CW'(-w_sel) : CW'(w_sel);

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < AxN; a++) scale_q[a] <= cas_pkg::OneQ16;
      filt_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cas_pkg::cfg_reg_e'(cfg_index_i))
        cas_pkg::CFG_SCALE_X:   scale_q[0] <= $signed(cfg_data_i);
        cas_pkg::CFG_SCALE_Y:   scale_q[1] <= $signed(cfg_data_i);
        cas_pkg::CFG_SCALE_Z:   scale_q[2] <= $signed(cfg_data_i);
        cas_pkg::CFG_FILTER_EN: filt_en_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Vertex memory: one write port at the fill count, one registered read port
  always_ff @(posedge clk_i) begin
    if (store_en) begin
      mem_q[count_q[AddrW-1:0]] <= {in_data_i.weight, in_data_i.coord_z,
                                    in_data_i.coord_y, in_data_i.coord_x};
    end
    if (cmd_i.op == cas_pkg::OP_READ) begin
      rd_q <= mem_q[k_q[AddrW-1:0]];
    end
  end

  // Accumulate sums, hand the set to the divider, step through the vertices
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      n_q     <= '0;
      k_q     <= '0;
      for (int a = 0; a < AxN; a++) sum_q[a] <= '0;
    end else begin
      case (cmd_i.op)
        cas_pkg::OP_LOAD: begin
          if (store_en) begin
            count_q <= count_q + CntW'(1);
            for (int a = 0; a < AxN; a++) sum_q[a] <= sum_q[a] + SumW'(in_p[a]);
          end
        end
        cas_pkg::OP_DIV_START: begin
          n_q     <= count_q;
          count_q <= '0;
          k_q     <= '0;
          for (int a = 0; a < AxN; a++) sum_q[a] <= '0;
        end
        cas_pkg::OP_FINAL: k_q <= k_q + CntW'(1);
        default: ;
      endcase
    end
  end

  // Lane arithmetic
  always_comb begin
    for (int a = 0; a < AxN; a++) begin
      // divider: one quotient bit per step
      rtrial[a]   = {rem_q[a], dsh_q[a][SumW-1]};
      rdiff[a]    = rtrial[a] - {1'b0, n_q};
      rge[a]      = (rtrial[a] >= {1'b0, n_q});
      smag_sum[a] = sum_q[a][SumW-1] ? SumW'(-sum_q[a]) : SumW'(sum_q[a]);
      cq[a]       = qneg_q[a] ? SumW'(-dsh_q[a]) : dsh_q[a];

      // displacement terms
      rd_p[a]  = $signed(rd_q[a*CW +: CW]);
      sneg[a]  = scale_q[a][CW-1];
      smag[a]  = sneg[a] ? CW'(-scale_q[a]) : CW'(scale_q[a]);
      diff[a]  = (CW+1)'(rd_p[a]) - (CW+1)'(c_q[a]);

      // one shared multiplier per lane
      if (cmd_i.op == cas_pkg::OP_MUL1) begin
        mul_a[a] = dmag_q[a];
        mul_b[a] = smag[a];
      end else if (cmd_i.op == cas_pkg::OP_MULHI) begin
        mul_a[a] = {15'b0, tmag_q[a][48:32]};
        mul_b[a] = wmag;
      end else begin
        mul_a[a] = tmag_q[a][31:0];
        mul_b[a] = wmag;
      end
      mul_res[a] = mul_a[a] * mul_b[a];
      rnd[a]     = prod_q[a] + 64'd32768;

      t_c[a]   = sgn_q[a] ? (50'(c_q[a]) - $signed({2'b00, m1_q[a]}))
                          : (50'(c_q[a]) + $signed({2'b00, m1_q[a]}));
      t_neg[a] = -t_q[a];

      msum[a] = 49'({hi_q[a][23:0], 16'b0}) + 49'(lor_q[a]);
      mbig[a] = (|hi_q[a][48:24]) | (|msum[a][48:40]);

      fval[a] = sgn_q[a] ? (-$signed({2'b00, m_q[a]}) - 43'(rd_p[a]))
                         : ($signed({2'b00, m_q[a]}) - 43'(rd_p[a]));
      if (fval[a] > FMax) begin
        disp[a] = FMax[CW-1:0];
      end else if (fval[a] < FMin) begin
        disp[a] = FMin[CW-1:0];
      end else begin
        disp[a] = fval[a][CW-1:0];
      end
    end
  end

  // Lane registers, advanced one micro-operation at a time
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < AxN; a++) begin
      case (cmd_i.op)
        cas_pkg::OP_DIV_START: begin
          dsh_q[a]  <= smag_sum[a];
          rem_q[a]  <= '0;
          qneg_q[a] <= sum_q[a][SumW-1];
        end
        cas_pkg::OP_DIV_STEP: begin
          rem_q[a] <= rge[a] ? rdiff[a][CntW-1:0] : rtrial[a][CntW-1:0];
          dsh_q[a] <= {dsh_q[a][SumW-2:0], rge[a]};
        end
        cas_pkg::OP_DIV_END: c_q[a] <= $signed(cq[a][CW-1:0]);
        cas_pkg::OP_DIFF: begin
          dneg_q[a] <= diff[a][CW];
          dmag_q[a] <= diff[a][CW] ? CW'(-diff[a]) : CW'(diff[a]);
        end
        cas_pkg::OP_MUL1: begin
          prod_q[a] <= mul_res[a];
          sgn_q[a]  <= dneg_q[a] ^ sneg[a];
        end
        cas_pkg::OP_ROUND1: m1_q[a] <= rnd[a][63:16];
        cas_pkg::OP_ADDC:   t_q[a]  <= t_c[a];
        cas_pkg::OP_MAGT: begin
          tneg_q[a] <= t_q[a][49];
          tmag_q[a] <= t_q[a][49] ? t_neg[a][48:0] : t_q[a][48:0];
        end
        cas_pkg::OP_MULLO: begin
          prod_q[a] <= mul_res[a];
          sgn_q[a]  <= tneg_q[a] ^ wneg;
        end
        cas_pkg::OP_MULHI: begin
          hi_q[a]  <= mul_res[a][48:0];
          lor_q[a] <= rnd[a][63:16];
        end
        cas_pkg::OP_COMB: m_q[a] <= mbig[a] ? MCap : msum[a][40:0];
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == cas_pkg::OP_FINAL) begin
      out_q.disp_x    <= disp[0];
      out_q.disp_y    <= disp[1];
      out_q.disp_z    <= disp[2];
      out_q.last_disp <= sts_o.last_k;
    end
  end

  assign out_data_o = out_q;

endmodule

@@ hw/rtl/centroid_axis_scaling.sv @@
// Top level of the centroid scaling block: controller plus datapath.
// Depends on cas_pkg, cas_ctrl and cas_dpath.
//
// Usage:
// - Input channel (in_valid_i / in_stall_o / in_data_i): one vertex per beat,
//   taken one per cycle while the block is loading. The beat with
//   last_vertex set closes the set; vertices beyond MAX_VERTICES are dropped,
//   but a dropped beat with last_vertex still closes the set.
// - Output channel (out_valid_o / out_stall_i / out_data_o): one displacement
//   beat per stored vertex, in load order; last_disp marks the final one.
// - Config channel (cfg_valid_i / cfg_ready_o): scale_x/y/z and filter_enable,
//   always ready; write only while the block is idle.
// - The centroid is formed after the closing beat by the restoring divider,
//   one quotient bit per cycle; then each displacement passes through the
//   per-axis multiply lanes, one shared multiplier per axis.
// - The input stalls from the closing beat until the final result sits in the
//   output register; the next set loads while that beat waits.
// - A stalled output holds its beat and pauses emission.
// - Reset clears sums, counts, the output valid and restores config defaults;
//   the vertex memory is not cleared.
module centroid_axis_scaling #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  cas_pkg::in_beat_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output cas_pkg::out_beat_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cas_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cas_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned CntW  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned AddrW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned SumW  = 31 + CntW;

  cas_pkg::dp_cmd_t cmd;
  cas_pkg::dp_sts_t sts;
  logic             cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  cas_ctrl #(
    .SumW (SumW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_data_i.last_vertex),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cas_dpath #(
    .MaxVertices (MAX_VERTICES),
    .AddrW       (AddrW),
    .CntW        (CntW),
    .SumW        (SumW)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ hw/rtl/cas_checker.sv @@
// Port-level checker of the centroid scaling block, bound to the top level.
// Depends on cas_pkg and centroid_axis_scaling.
module cas_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_o,
  input  cas_pkg::in_beat_t             in_data_i,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  cas_pkg::out_beat_t            out_data_o
);

  // Hold a stalled output beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

  // Stop loading once a set is closed
  a_close_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.last_vertex |=> in_stall_o)
    else $error("input taken right after the closing vertex");

  // Keep loading off while a set is still being emitted
  a_emit_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last_disp |-> in_stall_o)
    else $error("input open in the middle of an emission");

  // Only the final beat of a set may wait while loading
  a_load_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o || out_data_o.last_disp)
    else $error("non-final result pending while loading");

endmodule

bind centroid_axis_scaling cas_checker u_cas_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
